// File: rtl/salc_pkg.sv
// Shared types, sizes and codes for the set-associative LRU cache tag model.
// No dependencies; salc_lookup and the top level refer to this package by scoped names.
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int TAG_W    = 64;
    localparam int ADDR_W   = 64;
    localparam int CNT_W    = 32;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    // access kinds
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             extra_hit;
        logic [CNT_W-1:0] total_hits;
        logic [CNT_W-1:0] total_misses;
        logic [CNT_W-1:0] total_evictions;
    } t_out;

    // one set: all ways side by side
    typedef struct packed {
        logic [MAX_WAYS-1:0]              valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0]  rank;
        logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    } t_row;

    typedef struct packed {
        logic [1:0] outcome;
        t_row       row;
    } t_lookup;

endpackage

// File: rtl/salc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/salc_lookup.sv
// Tag compare, free-way and victim selection, and LRU rank update for one set.
// Depends on salc_pkg.
module salc_lookup (
    input  salc_pkg::t_row                  i_row,
    input  logic                            i_row_init,
    input  logic [salc_pkg::TAG_W-1:0]      i_tag,
    input  logic [salc_pkg::WCNT_W-1:0]     i_ways,
    output salc_pkg::t_lookup               o_res
);

    localparam int WCW = salc_pkg::WCNT_W;
    localparam int WW  = salc_pkg::WAY_W;
    localparam int RW  = salc_pkg::RANK_W;
    localparam int NW  = salc_pkg::MAX_WAYS;

    logic [NW-1:0] valid;
    logic [NW-1:0] in_use;
    logic [NW-1:0] hit_vec;
    logic [NW-1:0] free_vec;
    logic          hit_any;
    logic          free_any;
    logic [WW-1:0] hit_way;
    logic [WW-1:0] free_way;
    logic [WW-1:0] victim;
    logic [RW-1:0] vrank;
    logic [RW-1:0] limit;
    logic          age_all;
    logic [WW-1:0] sel_way;
    salc_pkg::t_row row_n;

    // never-written sets read as all invalid
    assign valid = i_row_init ? i_row.valid : '0;

    always_comb begin
        for (int w = 0; w < NW; w++) begin
            in_use[w]   = WCW'(w) < i_ways;
            hit_vec[w]  = in_use[w] && valid[w] && (i_row.tag[w] == i_tag);
            free_vec[w] = in_use[w] && !valid[w];
        end
        hit_any  = |hit_vec;
        free_any = |free_vec;

        // lowest-numbered match wins
        hit_way  = '0;
        free_way = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WW'(w);
            end
            if (free_vec[w]) begin
                free_way = WW'(w);
            end
        end

        // highest rank, ties to the lowest way
        victim = '0;
        vrank  = i_row.rank[0];
        for (int w = 1; w < NW; w++) begin
            if (in_use[w] && (i_row.rank[w] > vrank)) begin
                vrank  = i_row.rank[w];
                victim = WW'(w);
            end
        end

        if (hit_any) begin
            o_res.outcome = salc_pkg::OUT_HIT;
            limit         = i_row.rank[hit_way];
            age_all       = 1'b0;
            sel_way       = hit_way;
        end else if (free_any) begin
            o_res.outcome = salc_pkg::OUT_FILL;
            limit         = '0;
            age_all       = 1'b1;
            sel_way       = free_way;
        end else begin
            o_res.outcome = salc_pkg::OUT_EVICT;
            limit         = vrank;
            age_all       = 1'b0;
            sel_way       = victim;
        end

        // age the valid in-use lines more recent than the touched one (all of them on a fill), saturating at RANK_MAX
        row_n       = i_row;
        row_n.valid = valid;
        for (int w = 0; w < NW; w++) begin
            if (in_use[w] && valid[w] && (age_all || (i_row.rank[w] < limit))
                    && (i_row.rank[w] != salc_pkg::RANK_MAX)) begin
                row_n.rank[w] = i_row.rank[w] + RW'(1);
            end
        end
        row_n.valid[sel_way] = 1'b1;
        row_n.rank[sel_way]  = '0;
        row_n.tag[sel_way]   = i_tag;

        o_res.row = row_n;
    end

endmodule

// File: rtl/set_assoc_lru_cache_tag_model_unit.sv
// Set-associative LRU cache tag model: top level with set memory, control and counters.
// The accepting edge issues the set read; the set is written back at a later edge, once the
// result register can take the result. One access at a time: the input stalls during the
// read-modify-write of the set memory, and a stalled output holds the update state until the result register frees up.
// Reset (i_rst_n low, synchronous): counters clear, all sets read as empty, config returns
// to set_bits 4, block_bits 4, ways_in_use 1. No clearing pass: per-set flags mark written sets.
module set_assoc_lru_cache_tag_model_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // access input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  salc_pkg::t_in                       i_in_data,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output salc_pkg::t_out                      o_out_data,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SW  = salc_pkg::SET_W;
    localparam int WCW = salc_pkg::WCNT_W;
    localparam int CW  = salc_pkg::CNT_W;
    localparam int ROW_W = $bits(salc_pkg::t_row);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    // configuration
    logic [2:0]  r_set_bits;
    logic [5:0]  r_block_bits;
    logic [3:0]  r_ways;

    // control
    logic                    r_state;
    logic                    n_state;
    logic [salc_pkg::NUM_SETS-1:0] r_row_init;
    logic                    r_init_q;
    logic [SW-1:0]           r_set;
    logic [salc_pkg::TAG_W-1:0] r_tag;
    logic [1:0]              r_cmd;

    // counters and output
    logic [CW-1:0]  r_hits;
    logic [CW-1:0]  r_misses;
    logic [CW-1:0]  r_evicts;
    logic [CW-1:0]  n_hits;
    logic [CW-1:0]  n_misses;
    logic [CW-1:0]  n_evicts;
    logic           r_out_valid;
    salc_pkg::t_out r_out;

    // datapath
    logic                       in_fire;
    logic                       commit;
    logic [6:0]                 s_eff;
    logic [6:0]                 shamt;
    logic [SW-1:0]              set_mask;
    logic [salc_pkg::ADDR_W-1:0] set_raw;
    logic [SW-1:0]              set_idx;
    logic [salc_pkg::TAG_W-1:0] tag_in;
    logic [WCW-1:0]             ways_eff;
    logic [ROW_W-1:0]           rd_row;
    salc_pkg::t_lookup          look;
    logic [1:0]                 hit_inc;
    logic [CW:0]                hit_sum;

    // one access in flight; stall the input while its set is being updated
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    // write back only when the result register can take the result
    assign commit      = (r_state == ST_LOOK) && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;

    // address split: offset | set | tag, set width clamped to the stored maximum
    always_comb begin
        s_eff = (7'(r_set_bits) > 7'(salc_pkg::MAX_SET_BITS))
              ? 7'(salc_pkg::MAX_SET_BITS) : 7'(r_set_bits);
        for (int k = 0; k < SW; k++) begin
            set_mask[k] = 7'(k) < s_eff;
        end
        set_raw = i_in_data.address >> r_block_bits;
        set_idx = set_raw[SW-1:0] & set_mask;
        shamt   = s_eff + 7'(r_block_bits);
        // a split of 64 bits or more leaves no tag bits
        tag_in  = shamt[6] ? '0 : (i_in_data.address >> shamt[5:0]);
    end

    // ways in use, clamped to one .. MAX_WAYS
    always_comb begin
        if (r_ways == 4'd0) begin
            ways_eff = WCW'(1);
        end else if (32'(r_ways) > 32'(salc_pkg::MAX_WAYS)) begin
            ways_eff = WCW'(salc_pkg::MAX_WAYS);
        end else begin
            ways_eff = WCW'(r_ways);
        end
    end

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (salc_pkg::NUM_SETS)
    ) u_set_ram (
        .i_clk     (i_clk),
        .i_wr_en   (commit),
        .i_wr_addr (r_set),
        .i_wr_data (look.row),
        .i_rd_en   (in_fire),
        .i_rd_addr (set_idx),
        .o_rd_data (rd_row)
    );

    salc_lookup u_lookup (
        .i_row      (salc_pkg::t_row'(rd_row)),
        .i_row_init (r_init_q),
        .i_tag      (r_tag),
        .i_ways     (ways_eff),
        .o_res      (look)
    );

    // saturating counter updates; a modify adds one extra hit
    always_comb begin
        hit_inc = 2'((look.outcome == salc_pkg::OUT_HIT) ? 1 : 0)
                + 2'((r_cmd == salc_pkg::CMD_MODIFY) ? 1 : 0);
        hit_sum = {1'b0, r_hits} + (CW + 1)'(hit_inc);
        n_hits  = hit_sum[CW] ? '1 : hit_sum[CW-1:0];

        n_misses = r_misses;
        if ((look.outcome != salc_pkg::OUT_HIT) && (r_misses != '1)) begin
            n_misses = r_misses + CW'(1);
        end
        n_evicts = r_evicts;
        if ((look.outcome == salc_pkg::OUT_EVICT) && (r_evicts != '1)) begin
            n_evicts = r_evicts + CW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_row_init   <= '0;
            r_out_valid  <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_set_bits   <= 3'd4;
            r_block_bits <= 6'd4;
            r_ways       <= 4'd1;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    salc_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                    salc_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[5:0];
                    salc_pkg::CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (commit) begin
                r_row_init[r_set] <= 1'b1;
                r_hits            <= n_hits;
                r_misses          <= n_misses;
                r_evicts          <= n_evicts;
                r_out_valid       <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: capture the access, then the result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_set    <= set_idx;
            r_tag    <= tag_in;
            r_cmd    <= i_in_data.command;
            r_init_q <= r_row_init[set_idx];
        end
        if (commit) begin
            r_out.outcome         <= look.outcome;
            r_out.extra_hit       <= (r_cmd == salc_pkg::CMD_MODIFY);
            r_out.total_hits      <= n_hits;
            r_out.total_misses    <= n_misses;
            r_out.total_evictions <= n_evicts;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // a result appears only out of the set update cycle
    a_out_from_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_LOOK)
        else $error("result raised without a set update");

    // every eviction is also a miss
    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evicts <= r_misses)
        else $error("eviction count exceeds miss count");

    // the hit counter never moves backward outside reset
    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_hits >= $past(r_hits))
        else $error("hit count decreased");

    // the set memory is never written while a new set read is issued
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(commit && in_fire))
        else $error("set write overlaps a set read");
`endif

endmodule
